// ===== hdl/prb_pkg.sv =====
// Shared types, constants and helpers of the palette rotate-scale blitter.
package prb_pkg;

  localparam int OffsetW  = 24;
  localparam int WordW    = 32;
  localparam int ColorW   = 8;
  localparam int RgbW     = 24;
  localparam int ColW     = 12;
  localparam int ScaleW   = 4;
  localparam int RowPixW  = 14;
  localparam int IndexW   = 8;
  localparam int SrcXW    = 9;
  localparam int SrcYW    = 8;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 24;

  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = 1;

  typedef enum logic [1:0] {
    FUNC_PIXEL   = 2'd0,
    FUNC_PALETTE = 2'd1,
    FUNC_GAMMA   = 2'd2
  } func_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ROW_PIXELS   = 2'd0,
    REG_SCALE        = 2'd1,
    REG_BASE_OFFSET  = 2'd2,
    REG_FORMAT_10BIT = 2'd3
  } reg_index_t;

  // scale here is already clamped to 1..MAX_SCALE
  typedef struct packed {
    logic [RowPixW-1:0] row_pixels;
    logic [ScaleW-1:0]  scale;
    logic [OffsetW-1:0] base_offset;
    logic               format_10bit;
  } cfg_t;

  typedef struct packed {
    func_t             func;
    logic [IndexW-1:0] entry_index;
    logic [SrcXW-1:0]  src_x;
    logic [SrcYW-1:0]  src_y;
    logic [ColorW-1:0] red_in;
    logic [ColorW-1:0] green_in;
    logic [ColorW-1:0] blue_in;
    logic [ColorW-1:0] gamma_value;
  } item_t;

  // One expanded pixel: color word and the two partial offsets.
  typedef struct packed {
    logic [WordW-1:0]   word;
    logic [OffsetW-1:0] col_term;
    logic [OffsetW-1:0] row_base;
  } job_t;

  function automatic logic [WordW-1:0] make_word(input logic [RgbW-1:0] rgb,
                                                 input logic fmt10);
    logic [WordW-1:0] w;
    if (fmt10) begin
      w = {2'b00, rgb[23:16], 2'b00, rgb[15:8], 2'b00, rgb[7:0], 2'b00};
    end else begin
      w = {8'h00, rgb};
    end
    return w;
  endfunction

endpackage

// ===== hdl/prb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module prb_ram #(
  parameter int Width = 8,
  parameter int Depth = 256,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic             re,
  input  logic [AddrW-1:0] raddr,
  output logic [Width-1:0] rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/prb_front.sv =====
// Front end: accept items, run gamma and palette memories, build pixel jobs.
module prb_front import prb_pkg::*; #(
  parameter int SRC_HEIGHT      = 200,
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t item,
  output logic  job_valid,
  input  logic  job_ready,
  output job_t  job
);

  localparam int PalAddrW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam logic [OffsetW-1:0] RowTop   = OffsetW'(SRC_HEIGHT - 1);
  localparam logic [IndexW:0]    PalLimit = (IndexW + 1)'(PALETTE_ENTRIES);

  logic in_fire;
  logic gamma_we;

  // stage A: gamma data in flight
  logic               a_valid;
  logic               a_pixel;
  logic [IndexW-1:0]  a_index;
  logic [ColW-1:0]    a_col;
  logic [OffsetW-1:0] a_row;
  logic               a_ready;
  logic               a_adv;
  logic               a_in_range;

  // stage B: palette color in flight
  logic               b_valid;
  logic               b_ready;
  logic               b_in_range;
  logic [ColW-1:0]    b_col;
  logic [OffsetW-1:0] b_row;

  logic [ColW:0]          col_prod;
  logic [OffsetW-1:0]     rev_row;
  logic [OffsetW+ScaleW-1:0] row_prod;
  logic [RowPixW+ColW-1:0]   col_term_prod;

  logic [ColorW-1:0] gamma_r;
  logic [ColorW-1:0] gamma_g;
  logic [ColorW-1:0] gamma_b;
  logic [RgbW-1:0]   pal_rdata;
  logic              pal_we;
  logic              pal_re;

  assign in_fire  = in_valid && in_ready;
  assign gamma_we = in_fire && (item.func == FUNC_GAMMA);

  assign col_prod = cfg.scale * item.src_x;
  assign rev_row  = RowTop - {{(OffsetW - SrcYW){1'b0}}, item.src_y};
  assign row_prod = rev_row * cfg.scale;

  assign a_in_range = {1'b0, a_index} < PalLimit;
  assign a_adv      = a_valid && (!a_pixel || b_ready);
  assign a_ready    = !a_valid || a_adv;
  assign in_ready   = a_ready;

  assign pal_we = a_adv && !a_pixel && a_in_range;
  assign pal_re = a_adv && a_pixel;

  assign b_ready   = !b_valid || job_ready;
  assign job_valid = b_valid;

  assign col_term_prod = cfg.row_pixels * b_col;
  assign job.word      = make_word(b_in_range ? pal_rdata : '0, cfg.format_10bit);
  assign job.col_term  = col_term_prod[OffsetW-1:0];
  assign job.row_base  = b_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (a_ready) begin
        // gamma writes finish at accept; unused codes drop here
        a_valid <= in_fire &&
                   ((item.func == FUNC_PIXEL) || (item.func == FUNC_PALETTE));
      end
      if (b_ready) begin
        b_valid <= a_adv && a_pixel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_pixel <= (item.func == FUNC_PIXEL);
      a_index <= item.entry_index;
      a_col   <= col_prod[ColW-1:0];
      a_row   <= row_prod[OffsetW-1:0];
    end
    if (b_ready && a_adv && a_pixel) begin
      b_in_range <= a_in_range;
      b_col      <= a_col;
      b_row      <= a_row;
    end
  end

  prb_ram #(.Width(ColorW), .Depth(256)) u_gamma_r (
    .clk   (clk),
    .we    (gamma_we),
    .waddr (item.entry_index),
    .wdata (item.gamma_value),
    .re    (in_fire),
    .raddr (item.red_in),
    .rdata (gamma_r)
  );

  prb_ram #(.Width(ColorW), .Depth(256)) u_gamma_g (
    .clk   (clk),
    .we    (gamma_we),
    .waddr (item.entry_index),
    .wdata (item.gamma_value),
    .re    (in_fire),
    .raddr (item.green_in),
    .rdata (gamma_g)
  );

  prb_ram #(.Width(ColorW), .Depth(256)) u_gamma_b (
    .clk   (clk),
    .we    (gamma_we),
    .waddr (item.entry_index),
    .wdata (item.gamma_value),
    .re    (in_fire),
    .raddr (item.blue_in),
    .rdata (gamma_b)
  );

  prb_ram #(.Width(RgbW), .Depth(PALETTE_ENTRIES)) u_palette (
    .clk   (clk),
    .we    (pal_we),
    .waddr (a_index[PalAddrW-1:0]),
    .wdata ({gamma_r, gamma_g, gamma_b}),
    .re    (pal_re),
    .raddr (a_index[PalAddrW-1:0]),
    .rdata (pal_rdata)
  );

endmodule

// ===== hdl/prb_queue.sv =====
// Short job queue between the front end and the write expander.
module prb_queue import prb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  job_t in_job,
  output logic out_valid,
  input  logic out_ready,
  output job_t out_job
);

  job_t                 slots [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr;
  logic [QueuePtrW-1:0] rd_ptr;
  logic [QueuePtrW:0]   count;
  logic                 push;
  logic                 pop;

  assign in_ready  = (count != (QueuePtrW + 1)'(QueueDepth));
  assign out_valid = (count != '0);
  assign out_job   = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_job;
    end
  end

`ifndef SYNTH
  a_fill_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not rise on push");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> (count == $past(count) - 1'b1))
    else $error("queue count did not fall on pop");
`endif

endmodule

// ===== hdl/prb_back.sv =====
// Write expander: turn one job into scale*scale framebuffer writes.
module prb_back import prb_pkg::*; #(
  parameter int MAX_SCALE = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               job_valid,
  output logic               job_ready,
  input  job_t               job,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [OffsetW-1:0] out_offset,
  output logic [WordW-1:0]   out_word,
  output logic               out_last
);

  localparam int CntW = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;

  logic               active;
  logic [CntW-1:0]    sx;
  logic [CntW-1:0]    sy;
  logic [CntW-1:0]    s_last;
  logic [OffsetW-1:0] col_base;
  logic [OffsetW-1:0] col_acc;
  logic [OffsetW-1:0] row_acc;
  logic [WordW-1:0]   word;
  logic               out_free;
  logic               step;
  logic               at_end;
  logic               take;
  logic [ScaleW-1:0]  scale_m1;

  assign scale_m1  = cfg.scale - 1'b1;
  assign s_last    = scale_m1[CntW-1:0];
  assign out_free  = !out_valid || out_ready;
  assign step      = active && out_free;
  assign at_end    = (sx == s_last) && (sy == s_last);
  assign job_ready = !active || (step && at_end);
  assign take      = job_valid && job_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid <= active;
      end
      if (take) begin
        active <= 1'b1;
      end else if (step && at_end) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_offset <= cfg.base_offset + col_acc + row_acc;
      out_word   <= word;
      out_last   <= at_end;
    end
    if (take) begin
      sx       <= '0;
      sy       <= '0;
      col_base <= job.col_term;
      col_acc  <= job.col_term;
      row_acc  <= job.row_base;
      word     <= job.word;
    end else if (step) begin
      if (sx == s_last) begin
        // next framebuffer position inside the reversed row
        sx      <= '0;
        sy      <= sy + 1'b1;
        col_acc <= col_base;
        row_acc <= row_acc + 1'b1;
      end else begin
        sx      <= sx + 1'b1;
        col_acc <= col_acc + {{(OffsetW - RowPixW){1'b0}}, cfg.row_pixels};
      end
    end
  end

`ifndef SYNTH
  a_last_marked: assert property (@(posedge clk) disable iff (rst)
    (step && at_end) |=> (out_valid && out_last))
    else $error("final write of a pixel not marked last");

  a_hold_count: assert property (@(posedge clk) disable iff (rst)
    (active && !out_free) |=> ($stable(sx) && $stable(sy)))
    else $error("write counters moved while output stalled");
`endif

endmodule

// ===== hdl/palette_rotate_scale_blitter.sv =====
// Top level of the palette rotate-scale blitter: ports, config registers, wiring.
//
// Channel  Dir  Handshake        Payload
// s_*      in   tvalid/tready    tuser: func; tdata: index, x, y, r, g, b, gamma
// m_*      out  tvalid/tready    tdata: fb_offset, pixel_word; tlast: last write
// cfg_*    in   cfg_we           cfg_index selects register, cfg_wdata value
//
// A source pixel occupies the write expander for scale*scale framebuffer writes,
// one write per cycle while m_tready allows; gamma, palette and unused items
// produce nothing. The front end takes one item per cycle unless stalled from
// behind, and runs ahead of the expander by a two-entry job queue. Reset clears
// control and config; gamma and palette memories are not cleared. Either side
// may stall at will.
module palette_rotate_scale_blitter import prb_pkg::*; #(
  parameter int SRC_HEIGHT      = 200,
  parameter int MAX_SCALE       = 8,
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // [7:0] entry_index, [16:8] src_x, [24:17] src_y, [32:25] red_in,
  // [40:33] green_in, [48:41] blue_in, [56:49] gamma_value, [63:57] zero
  input  logic [63:0]         s_tdata,
  // [1:0] func
  input  logic [1:0]          s_tuser,
  output logic                m_tvalid,
  input  logic                m_tready,
  // [23:0] fb_offset, [55:24] pixel_word
  output logic [55:0]         m_tdata,
  output logic                m_tlast,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  // config registers
  logic [RowPixW-1:0] row_pixels;
  logic [ScaleW-1:0]  scale;
  logic [OffsetW-1:0] base_offset;
  logic               format_10bit;
  logic [ScaleW-1:0]  scale_eff;
  cfg_t               cfg;

  item_t              item;
  logic               job_in_valid;
  logic               job_in_ready;
  job_t               job_in;
  logic               job_out_valid;
  logic               job_out_ready;
  job_t               job_out;
  logic [OffsetW-1:0] fb_offset;
  logic [WordW-1:0]   pixel_word;

  // Write registers; index decode covers every code of the port.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_pixels   <= '0;
      scale        <= ScaleW'(1);
      base_offset  <= '0;
      format_10bit <= 1'b0;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_ROW_PIXELS:   row_pixels   <= cfg_wdata[RowPixW-1:0];
        REG_SCALE:        scale        <= cfg_wdata[ScaleW-1:0];
        REG_BASE_OFFSET:  base_offset  <= cfg_wdata[OffsetW-1:0];
        REG_FORMAT_10BIT: format_10bit <= cfg_wdata[0];
        default:          ;
      endcase
    end
  end

  // Clamp scale: zero acts as one, anything above the limit as the limit.
  always_comb begin
    if (scale == '0) begin
      scale_eff = ScaleW'(1);
    end else if (scale > ScaleW'(MAX_SCALE)) begin
      scale_eff = ScaleW'(MAX_SCALE);
    end else begin
      scale_eff = scale;
    end
  end

  assign cfg.row_pixels   = row_pixels;
  assign cfg.scale        = scale_eff;
  assign cfg.base_offset  = base_offset;
  assign cfg.format_10bit = format_10bit;

  // Unpack the input item.
  assign item.func        = func_t'(s_tuser);
  assign item.entry_index = s_tdata[7:0];
  assign item.src_x       = s_tdata[16:8];
  assign item.src_y       = s_tdata[24:17];
  assign item.red_in      = s_tdata[32:25];
  assign item.green_in    = s_tdata[40:33];
  assign item.blue_in     = s_tdata[48:41];
  assign item.gamma_value = s_tdata[56:49];

  prb_front #(
    .SRC_HEIGHT      (SRC_HEIGHT),
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .item      (item),
    .job_valid (job_in_valid),
    .job_ready (job_in_ready),
    .job       (job_in)
  );

  prb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (job_in_valid),
    .in_ready  (job_in_ready),
    .in_job    (job_in),
    .out_valid (job_out_valid),
    .out_ready (job_out_ready),
    .out_job   (job_out)
  );

  prb_back #(
    .MAX_SCALE (MAX_SCALE)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .job_valid  (job_out_valid),
    .job_ready  (job_out_ready),
    .job        (job_out),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_offset (fb_offset),
    .out_word   (pixel_word),
    .out_last   (m_tlast)
  );

  assign m_tdata = {pixel_word, fb_offset};

endmodule
